// ----- hdl/lrec_pkg.sv -----
package lrec_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [DATA_W-1:0] DIGIT_BIAS = 32'd48;

  function automatic logic is_operator(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_LF) || (c == CH_TAB) || (c == CH_BEL) || (c == CH_SPACE);
  endfunction

  function automatic op_e op_of(input logic [CHAR_W-1:0] c);
    op_e r;
    r = OP_DIV;
    if (c == CH_PLUS) begin
      r = OP_ADD;
    end else if (c == CH_MINUS) begin
      r = OP_SUB;
    end else if (c == CH_STAR) begin
      r = OP_MUL;
    end
    return r;
  endfunction

endpackage

// ----- hdl/lrec_mul.sv -----
module lrec_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lrec_pkg::DATA_W-1:0]  a_i,
  input  logic [lrec_pkg::DATA_W-1:0]  b_i,
  output logic [lrec_pkg::DATA_W-1:0]  result_o,
  output logic                         done_o
);

  logic [lrec_pkg::DATA_W-1:0] a_q, a_d, b_q, b_d, p_q, p_d;
  logic [lrec_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_d = p_q + a_q;
      end
      a_d   = {a_q[lrec_pkg::DATA_W-2:0], 1'b0};
      b_d   = {1'b0, b_q[lrec_pkg::DATA_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lrec_pkg::CNT_W'(lrec_pkg::DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign result_o = p_q;
  assign done_o   = done_q;

endmodule

// ----- hdl/lrec_div.sv -----
module lrec_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lrec_pkg::DATA_W-1:0]  a_i,
  input  logic [lrec_pkg::DATA_W-1:0]  b_i,
  output logic [lrec_pkg::DATA_W-1:0]  result_o,
  output logic                         done_o
);

  localparam int unsigned W = lrec_pkg::DATA_W;

  logic [W-1:0]               b_q, b_d, rem_q, rem_d, quo_q, quo_d;
  logic                       neg_q, neg_d;
  logic [lrec_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       run_q, run_d, fix_q, fix_d, done_q, done_d;
  logic [W:0]                 shifted, trial;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, b_q};
    b_d     = b_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    fix_d   = 1'b0;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d = a_i[W-1] ? (~a_i + 1'b1) : a_i;
      b_d   = b_i[W-1] ? (~b_i + 1'b1) : b_i;
      neg_d = a_i[W-1] ^ b_i[W-1];
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial[W]) begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lrec_pkg::CNT_W'(W - 1)) begin
        run_d = 1'b0;
        fix_d = 1'b1;
      end
    end else if (fix_q) begin
      if (neg_q) begin
        quo_d = ~quo_q + 1'b1;
      end
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      fix_q  <= fix_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign result_o = quo_q;
  assign done_o   = done_q;

endmodule

// ----- hdl/left_to_right_expression_calculator.sv -----
// Items are taken one at a time: a digit is folded into the operand in S_FOLD1 and S_FOLD2,
// an operator applies the pending operation in S_APPLY, waiting in S_WAIT after * or after /
// with a nonzero divisor for the bit-serial multiplier and divider, which each handle one bit
// of the operand per cycle. The item marked last then applies the pending operation and loads
// the output register, which can hold a result while the next item is taken.
// The asynchronous active-low reset clears accumulator, operand, flags and output valid.
module left_to_right_expression_calculator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lrec_pkg::CHAR_W-1:0]  char_code_i,
  input  logic                         end_of_expr_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [lrec_pkg::DATA_W-1:0] value_o,
  output logic                         div_zero_seen_o,
  output logic                         bad_char_seen_o
);

  localparam int unsigned W = lrec_pkg::DATA_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FOLD1 = 3'd1;
  localparam logic [2:0] S_FOLD2 = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [W-1:0]                  acc_q, acc_d, opnd_q, opnd_d;
  lrec_pkg::op_e                 pend_q, pend_d, new_op_q, new_op_d;
  logic                          div_err_q, div_err_d, ws_q, ws_d, is_op_q, is_op_d;
  logic [lrec_pkg::CHAR_W-1:0]   char_q, char_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  logic [W-1:0]                  out_value_q, out_value_d;
  logic                          out_dz_q, out_dz_d, out_bc_q, out_bc_d;
  logic                          mul_start, div_start, mul_done, div_done, finish;
  logic [W-1:0]                  mul_res, div_res;

  lrec_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (acc_q),
    .b_i      (opnd_q),
    .result_o (mul_res),
    .done_o   (mul_done)
  );

  lrec_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .a_i      (acc_q),
    .b_i      (opnd_q),
    .result_o (div_res),
    .done_o   (div_done)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    opnd_d      = opnd_q;
    pend_d      = pend_q;
    new_op_d    = new_op_q;
    div_err_d   = div_err_q;
    ws_d        = ws_q;
    is_op_d     = is_op_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_dz_d    = out_dz_q;
    out_bc_d    = out_bc_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    finish      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          char_d = char_code_i;
          last_d = end_of_expr_i;
          if (lrec_pkg::is_operator(char_code_i)) begin
            new_op_d = lrec_pkg::op_of(char_code_i);
            is_op_d  = 1'b1;
            state_d  = S_APPLY;
          end else if (lrec_pkg::is_space(char_code_i)) begin
            ws_d    = 1'b1;
            state_d = end_of_expr_i ? S_APPLY : S_IDLE;
          end else begin
            state_d = S_FOLD1;
          end
        end
      end
      S_FOLD1: begin
        opnd_d  = {opnd_q[W-4:0], 3'b000} + {opnd_q[W-2:0], 1'b0};
        state_d = S_FOLD2;
      end
      S_FOLD2: begin
        opnd_d  = opnd_q + {{(W - lrec_pkg::CHAR_W){1'b0}}, char_q} - lrec_pkg::DIGIT_BIAS;
        state_d = last_q ? S_APPLY : S_IDLE;
      end
      S_APPLY: begin
        unique case (pend_q)
          lrec_pkg::OP_ADD: begin
            acc_d  = acc_q + opnd_q;
            opnd_d = '0;
            finish = 1'b1;
          end
          lrec_pkg::OP_SUB: begin
            acc_d  = acc_q - opnd_q;
            opnd_d = '0;
            finish = 1'b1;
          end
          lrec_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_d   = S_WAIT;
          end
          lrec_pkg::OP_DIV: begin
            if (opnd_q == '0) begin
              div_err_d = 1'b1;
              finish    = 1'b1;
            end else begin
              div_start = 1'b1;
              state_d   = S_WAIT;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_WAIT: begin
        if (mul_done) begin
          acc_d  = mul_res;
          opnd_d = '0;
          finish = 1'b1;
        end else if (div_done) begin
          acc_d  = div_res;
          opnd_d = '0;
          finish = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = acc_q;
          out_dz_d    = div_err_q;
          out_bc_d    = ws_q;
          acc_d       = '0;
          opnd_d      = '0;
          pend_d      = lrec_pkg::OP_ADD;
          div_err_d   = 1'b0;
          ws_d        = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      if (is_op_q) begin
        pend_d  = new_op_q;
        is_op_d = 1'b0;
        state_d = last_q ? S_APPLY : S_IDLE;
      end else begin
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      opnd_q      <= '0;
      pend_q      <= lrec_pkg::OP_ADD;
      div_err_q   <= 1'b0;
      ws_q        <= 1'b0;
      is_op_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      opnd_q      <= opnd_d;
      pend_q      <= pend_d;
      div_err_q   <= div_err_d;
      ws_q        <= ws_d;
      is_op_q     <= is_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_op_q    <= new_op_d;
    char_q      <= char_d;
    last_q      <= last_d;
    out_value_q <= out_value_d;
    out_dz_q    <= out_dz_d;
    out_bc_q    <= out_bc_d;
  end

  assign out_valid_o     = out_valid_q;
  assign value_o         = out_value_q;
  assign div_zero_seen_o = out_dz_q;
  assign bad_char_seen_o = out_bc_q;

endmodule

// ----- hdl/lrec_checker.sv -----
module lrec_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [lrec_pkg::CHAR_W-1:0]        char_code_i,
  input logic                               end_of_expr_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [lrec_pkg::DATA_W-1:0] value_o,
  input logic                               div_zero_seen_o,
  input logic                               bad_char_seen_o
);

  // A stalled result must be held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o)
      && $stable(div_zero_seen_o) && $stable(bad_char_seen_o))
    else $error("stalled result changed");

  // The last item of an expression always needs further work before the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_expr_i |=> !in_ready_o)
    else $error("input taken straight after the last item");

  // After a digit is taken, input is not ready while the digit is folded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !lrec_pkg::is_operator(char_code_i)
      && !lrec_pkg::is_space(char_code_i) |=> !in_ready_o)
    else $error("input taken during digit folding");

  // A new result is only presented right after the input side was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an expression in progress");

endmodule

bind left_to_right_expression_calculator lrec_checker u_lrec_checker (.*);
